[src/svl_pkg.sv]
package svl_pkg;

    localparam int CFG_W   = 15;
    localparam int SPEED_W = 16;
    localparam int ADDR_W  = 5;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_MAX_LINEAR  = 3'd0;
    localparam logic [2:0] REG_MIN_LINEAR  = 3'd1;
    localparam logic [2:0] REG_MAX_ANGULAR = 3'd2;
    localparam logic [2:0] REG_MIN_ANGULAR = 3'd3;
    localparam logic [2:0] REG_SAFETY_RAD  = 3'd4;

    localparam logic [CFG_W-1:0] RST_MAX_LINEAR  = 15'd819;
    localparam logic [CFG_W-1:0] RST_MIN_LINEAR  = 15'd205;
    localparam logic [CFG_W-1:0] RST_MAX_ANGULAR = 15'd4096;
    localparam logic [CFG_W-1:0] RST_MIN_ANGULAR = 15'd41;
    localparam logic [CFG_W-1:0] RST_SAFETY_RAD  = 15'd1638;

    typedef struct packed {
        logic [CFG_W-1:0] max_linear;
        logic [CFG_W-1:0] min_linear;
        logic [CFG_W-1:0] max_angular;
        logic [CFG_W-1:0] min_angular;
        logic [CFG_W-1:0] bubble_radius;
    } svl_cfg_t;

endpackage

[src/svl_ifs.sv]
interface svl_req_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [3:0]         sensor_index;
    logic               last_point;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] cmd_x;
    logic signed [15:0] cmd_y;
    logic signed [15:0] cmd_rot;

    modport source
    (
        output valid, action, sensor_index, last_point, point_x, point_y,
               cmd_x, cmd_y, cmd_rot,
        input  ready
    );
    modport sink
    (
        input  valid, action, sensor_index, last_point, point_x, point_y,
               cmd_x, cmd_y, cmd_rot,
        output ready
    );
endinterface

interface svl_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_rot;
    logic               breach;
    logic               apply;

    modport source
    (
        output valid, out_x, out_y, out_rot, breach, apply,
        input  ready
    );
    modport sink
    (
        input  valid, out_x, out_y, out_rot, breach, apply,
        output ready
    );
endinterface

[src/safe_velocity_limiter.sv]
// channel  dir   handshake      payload
// req      in    valid/ready    action, sensor_index, last_point, point_x/y, cmd_x/y/rot
// rsp      out   valid/ready    out_x, out_y, out_rot, breach, apply
// apb      in    psel/penable   paddr, pwdata, prdata (pready tied high)
//
// a sensor item is never answered
// a velocity item with valid readings feeds one squaring multiplier the radius,
// then x and y of each point
// a velocity item without readings gives no result
// rst_n clears the limits to defaults, the point table to the origin and the flag
// a held result lets req keep flowing; the next result waits in S_OUT until taken
module safe_velocity_limiter
#(
    parameter int NUM_SENSORS = 9
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    svl_req_if.sink                     req,
    svl_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [svl_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SENSORS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RAD   = 3'd1;
    localparam logic [2:0] S_PX    = 3'd2;
    localparam logic [2:0] S_PY    = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // what the square register holds this cycle
    localparam logic [1:0] TAG_NONE = 2'd0;
    localparam logic [1:0] TAG_R    = 2'd1;
    localparam logic [1:0] TAG_X    = 2'd2;
    localparam logic [1:0] TAG_Y    = 2'd3;

    svl_pkg::svl_cfg_t cfg;

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [1:0]         tag_reg, tag_next;
    logic               readings_reg, readings_next;
    logic [29:0]        r2_reg;
    logic [30:0]        xsq_reg;
    logic               breach_reg, breach_next;
    logic signed [15:0] vx_reg, vy_reg, vr_reg;
    logic               rsp_valid_reg;
    logic signed [15:0] rsp_x_reg, rsp_y_reg, rsp_rot_reg;
    logic               rsp_breach_reg;

    logic               accept;
    logic               pt_wr;
    logic signed [15:0] px, py;
    logic signed [16:0] operand;
    logic [30:0]        square;
    logic [31:0]        dist2;
    logic               load_rsp;
    logic               take_rsp;

    function automatic logic signed [15:0] clamp_speed
    (
        input logic signed [15:0] v,
        input logic [14:0]        hi,
        input logic [14:0]        lo
    );
        logic signed [16:0] ve;
        logic [16:0]        mag;
        logic signed [16:0] hs;
        logic signed [16:0] ls;
        logic signed [15:0] res;
        ve  = {v[15], v};
        mag = v[15] ? 17'(-ve) : 17'(ve);
        hs  = {2'b00, hi};
        ls  = {2'b00, lo};
        // max test first, so min above max still yields max for big inputs
        if (mag > {2'b00, hi})
            res = v[15] ? 16'(-hs) : 16'(hs);
        else if ((mag != 17'd0) && (mag < {2'b00, lo}))
            res = v[15] ? 16'(-ls) : 16'(ls);
        else
            res = v;
        return res;
    endfunction

    svl_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    svl_points #(.NUM_SENSORS(NUM_SENSORS), .IDX_W(IDX_W)) u_points
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (pt_wr),
        .wr_index (req.sensor_index),
        .wr_x     (req.point_x),
        .wr_y     (req.point_y),
        .rd_index (idx_reg),
        .rd_x     (px),
        .rd_y     (py)
    );

    svl_sqr u_sqr
    (
        .clk     (clk),
        .operand (operand),
        .square  (square)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    // out-of-range index matches no slot inside svl_points
    assign pt_wr     = accept && !req.action;

    assign take_rsp  = rsp_valid_reg && rsp.ready;
    assign load_rsp  = (state_reg == S_OUT) && (!rsp_valid_reg || rsp.ready);

    // squared distance of the point whose y^2 just landed
    assign dist2 = {1'b0, xsq_reg} + {1'b0, square};

    // feed the shared squaring unit
    always_comb
    begin
        case (state_reg)
            S_RAD:   operand = {2'b00, cfg.bubble_radius};
            S_PX:    operand = {px[15], px};
            S_PY:    operand = {py[15], py};
            default: operand = '0;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        tag_next      = TAG_NONE;
        readings_next = readings_reg;
        breach_next   = breach_reg;

        // consume last cycle's square
        if ((tag_reg == TAG_Y) && (dist2 <= {2'b00, r2_reg}))
            breach_next = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!req.action)
                    begin
                        if (req.last_point)
                            readings_next = 1'b1;
                    end
                    else if (readings_reg)
                    begin
                        state_next  = S_RAD;
                        breach_next = 1'b0;
                        idx_next    = '0;
                    end
                end
            end
            S_RAD:
            begin
                tag_next   = TAG_R;
                state_next = S_PX;
            end
            S_PX:
            begin
                tag_next   = TAG_X;
                state_next = S_PY;
            end
            S_PY:
            begin
                tag_next = TAG_Y;
                if (idx_reg == LAST_IDX)
                    state_next = S_DRAIN;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PX;
                end
            end
            S_DRAIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_rsp)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            tag_reg       <= TAG_NONE;
            readings_reg  <= 1'b0;
            breach_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            tag_reg      <= tag_next;
            readings_reg <= readings_next;
            breach_reg   <= breach_next;
            if (load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (take_rsp)
                rsp_valid_reg <= 1'b0;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept && req.action)
        begin
            vx_reg <= clamp_speed(req.cmd_x, cfg.max_linear, cfg.min_linear);
            vy_reg <= clamp_speed(req.cmd_y, cfg.max_linear, cfg.min_linear);
            vr_reg <= clamp_speed(req.cmd_rot, cfg.max_angular, cfg.min_angular);
        end
        if (tag_reg == TAG_R)
            r2_reg <= square[29:0];
        if (tag_reg == TAG_X)
            xsq_reg <= square;
        if (load_rsp)
        begin
            rsp_x_reg      <= vx_reg;
            rsp_y_reg      <= vy_reg;
            rsp_rot_reg    <= vr_reg;
            rsp_breach_reg <= breach_reg;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.out_x   = rsp_x_reg;
    assign rsp.out_y   = rsp_y_reg;
    assign rsp.out_rot = rsp_rot_reg;
    assign rsp.breach  = rsp_breach_reg;
    assign rsp.apply   = !rsp_breach_reg;

    // a result only ever follows a completed sensor set
    a_rsp_needs_readings: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> readings_reg)
        else $error("result without valid readings");

    // point walk never runs past the table
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PX || state_reg == S_PY) |-> (32'(idx_reg) < NUM_SENSORS))
        else $error("point index out of range");

    // a velocity item with readings starts the radius square next cycle
    a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action && readings_reg) |=> (state_reg == S_RAD))
        else $error("sequencer did not start");

    // the radius square is always taken before any point square
    a_radius_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PX && idx_reg == '0) |-> (tag_reg == TAG_R))
        else $error("point walk without radius");

endmodule

[src/svl_regs.sv]
module svl_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [svl_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output svl_pkg::svl_cfg_t           cfg
);

    svl_pkg::svl_cfg_t cfg_reg;
    logic [2:0]        idx;
    logic              wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_linear    <= svl_pkg::RST_MAX_LINEAR;
            cfg_reg.min_linear    <= svl_pkg::RST_MIN_LINEAR;
            cfg_reg.max_angular   <= svl_pkg::RST_MAX_ANGULAR;
            cfg_reg.min_angular   <= svl_pkg::RST_MIN_ANGULAR;
            cfg_reg.bubble_radius <= svl_pkg::RST_SAFETY_RAD;
        end
        else if (wr_en)
        begin
            case (idx)
                svl_pkg::REG_MAX_LINEAR:  cfg_reg.max_linear    <= pwdata[14:0];
                svl_pkg::REG_MIN_LINEAR:  cfg_reg.min_linear    <= pwdata[14:0];
                svl_pkg::REG_MAX_ANGULAR: cfg_reg.max_angular   <= pwdata[14:0];
                svl_pkg::REG_MIN_ANGULAR: cfg_reg.min_angular   <= pwdata[14:0];
                svl_pkg::REG_SAFETY_RAD:  cfg_reg.bubble_radius <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            svl_pkg::REG_MAX_LINEAR:  prdata = {17'd0, cfg_reg.max_linear};
            svl_pkg::REG_MIN_LINEAR:  prdata = {17'd0, cfg_reg.min_linear};
            svl_pkg::REG_MAX_ANGULAR: prdata = {17'd0, cfg_reg.max_angular};
            svl_pkg::REG_MIN_ANGULAR: prdata = {17'd0, cfg_reg.min_angular};
            svl_pkg::REG_SAFETY_RAD:  prdata = {17'd0, cfg_reg.bubble_radius};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

[src/svl_points.sv]
module svl_points
#(
    parameter int NUM_SENSORS = 9,
    parameter int IDX_W       = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [3:0]         wr_index,
    input  logic signed [15:0] wr_x,
    input  logic signed [15:0] wr_y,
    input  logic [IDX_W-1:0]   rd_index,
    output logic signed [15:0] rd_x,
    output logic signed [15:0] rd_y
);

    logic signed [15:0] x_reg [NUM_SENSORS];
    logic signed [15:0] y_reg [NUM_SENSORS];

    // unwritten slots read as the origin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                x_reg[i] <= '0;
                y_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                if (wr_en && (32'(wr_index) == 32'(i)))
                begin
                    x_reg[i] <= wr_x;
                    y_reg[i] <= wr_y;
                end
            end
        end
    end

    assign rd_x = x_reg[rd_index];
    assign rd_y = y_reg[rd_index];

endmodule

[src/svl_sqr.sv]
module svl_sqr
(
    input  logic               clk,
    input  logic signed [16:0] operand,
    output logic [30:0]        square
);

    logic signed [33:0] prod;
    logic [30:0]        square_reg;

    // largest square is 32768^2 = 2^30
    assign prod   = operand * operand;
    assign square = square_reg;

    always_ff @(posedge clk)
    begin
        square_reg <= prod[30:0];
    end

endmodule
